[sv/bmss_pkg.sv]
// Shared types, register indexes and helper functions for the screen selector.
package bmss_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned ScrW    = 3;
	localparam int unsigned CntW    = 4;
	localparam int unsigned TimeW   = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AUTO_PERIOD  = 3'd0,
		REG_RETURN_AUTO  = 3'd1,
		REG_LONG_PRESS   = 3'd2,
		REG_DEBOUNCE     = 3'd3,
		REG_SCREEN_COUNT = 3'd4
	} cfg_reg_t;

	localparam logic [TimeW-1:0] AutoPeriodRst  = 32'd5000;
	localparam logic [TimeW-1:0] ReturnAutoRst  = 32'd15000;
	localparam logic [TimeW-1:0] LongPressRst   = 32'd500;
	localparam logic [TimeW-1:0] DebounceRst    = 32'd50;
	localparam logic [CntW-1:0]  ScreenCountRst = 4'd5;

	localparam logic [ScrW-1:0] ScrHome = 3'd0;
	localparam logic [ScrW-1:0] ScrAlt  = 3'd1;
	localparam logic [ScrW-1:0] ScrIp   = 3'd3;

	typedef struct packed {
		logic [TimeW-1:0] now_ms;
		logic             button_released;
	} in_t;

	typedef struct packed {
		logic [ScrW-1:0] screen;
		logic            auto_mode;
		logic            next_expression;
		logic            toggle_ip;
	} out_t;

	typedef struct packed {
		logic [TimeW-1:0] auto_period_ms;
		logic [TimeW-1:0] return_auto_ms;
		logic [TimeW-1:0] long_press_ms;
		logic [TimeW-1:0] debounce_ms;
		logic [CntW-1:0]  screen_count;
	} cfg_t;

	// Next screen, wrapped to the clamped count (zero acts as one, above eight as eight).
	function automatic logic [ScrW-1:0] advance_screen(logic [ScrW-1:0] s, logic [CntW-1:0] cnt);
		logic [CntW-1:0] n;
		logic [CntW-1:0] r;
		n = cnt;
		if (n == '0) n = 4'd1;
		if (n > 4'd8) n = 4'd8;
		r = {1'b0, s} + 4'd1;
		for (int i = 0; i < 8; i++) begin
			if (r >= n) r = r - n;
		end
		return r[ScrW-1:0];
	endfunction

endpackage

[sv/button_menu_screen_selector.sv]
// Button-driven menu screen selector with automatic toggling: top level.
//
// Usage: each input beat on in_data is one poll carrying a millisecond
// timestamp and the raw button level; each poll yields exactly one output
// beat on out_data with the screen, the auto flag and two one-shot actions.
// Both channels use valid/ready. Configuration is written through cfg_wen,
// cfg_idx and cfg_wdata; the user must write it only while no poll is in
// flight, and the block itself does not enforce this. A poll accepted into
// the input stage is evaluated against the selector state and registered
// into the output register, which drives out_valid, once that slot is free.
// Throughput: one poll per cycle while out_ready stays high; the state
// update is a handful of 32-bit subtract/compare operations between the
// input stage and the output register.
// Reset (arst_n low): configuration returns to its defaults, the selector
// goes to screen 0 in auto mode and both stages empty out.
// When out_ready is low the output beat holds, one more poll waits in the
// input stage, and in_ready drops until the output is taken.
module button_menu_screen_selector import bmss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [TimeW-1:0]   cfg_wdata
);

	cfg_t cfg;
	in_t  poll_s1;
	logic vld_s1;
	out_t res;
	out_t out_q;
	logic out_vld_q;
	logic adv;

	assign adv      = !out_vld_q || out_ready;
	assign in_ready = !vld_s1 || adv;

	bmss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bmss_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (vld_s1 && adv),
		.poll   (poll_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (adv) out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) poll_s1 <= in_data;
		if (adv && vld_s1) out_q <= res;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

[sv/bmss_cfg.sv]
// Configuration register file for the screen selector.
module bmss_cfg import bmss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [TimeW-1:0]   cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_period_ms <= AutoPeriodRst;
			cfg_q.return_auto_ms <= ReturnAutoRst;
			cfg_q.long_press_ms  <= LongPressRst;
			cfg_q.debounce_ms    <= DebounceRst;
			cfg_q.screen_count   <= ScreenCountRst;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_AUTO_PERIOD:  cfg_q.auto_period_ms <= cfg_wdata;
				REG_RETURN_AUTO:  cfg_q.return_auto_ms <= cfg_wdata;
				REG_LONG_PRESS:   cfg_q.long_press_ms  <= cfg_wdata;
				REG_DEBOUNCE:     cfg_q.debounce_ms    <= cfg_wdata;
				REG_SCREEN_COUNT: cfg_q.screen_count   <= cfg_wdata[CntW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/bmss_state.sv]
// Selector state registers and the per-poll update logic.
module bmss_state import bmss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  in_t  poll,
	input  cfg_t cfg,
	output out_t res
);

	logic [ScrW-1:0]  screen_q;
	logic             auto_q;
	logic [TimeW-1:0] last_auto_q;
	logic [TimeW-1:0] last_click_q;
	logic [TimeW-1:0] press_start_q;
	logic             held_q;

	logic [ScrW-1:0]  screen_d;
	logic             auto_d;
	logic [TimeW-1:0] last_auto_d;
	logic [TimeW-1:0] last_click_d;
	logic [TimeW-1:0] press_start_d;
	logic             held_d;
	logic             expr_d;
	logic             ip_d;
	logic [TimeW-1:0] since_auto;
	logic [TimeW-1:0] since_click;
	logic [TimeW-1:0] dur;
	logic             is_long;

	assign since_auto  = poll.now_ms - last_auto_q;
	assign since_click = poll.now_ms - last_click_q;
	assign dur         = poll.now_ms - press_start_q;
	assign is_long     = dur >= cfg.long_press_ms;

	always_comb begin
		screen_d      = screen_q;
		auto_d        = auto_q;
		last_auto_d   = last_auto_q;
		last_click_d  = last_click_q;
		press_start_d = press_start_q;
		held_d        = held_q;
		expr_d        = 1'b0;
		ip_d          = 1'b0;

		// Timer check comes before the button.
		if (auto_q) begin
			if (since_auto > cfg.auto_period_ms) begin
				screen_d    = (screen_q == ScrHome) ? ScrAlt : ScrHome;
				last_auto_d = poll.now_ms;
			end
		end else if (since_click > cfg.return_auto_ms) begin
			auto_d      = 1'b1;
			screen_d    = ScrHome;
			last_auto_d = poll.now_ms;
		end

		if (!poll.button_released && !held_q) begin
			held_d        = 1'b1;
			press_start_d = poll.now_ms;
		end

		if (poll.button_released && held_q) begin
			held_d = 1'b0;
			if (dur > cfg.debounce_ms) begin
				last_click_d = poll.now_ms;
				auto_d       = 1'b0;
				if (screen_d == ScrHome) begin
					if (is_long) screen_d = advance_screen(screen_d, cfg.screen_count);
					else expr_d = 1'b1;
				end else if (screen_d == ScrIp) begin
					if (is_long) ip_d = 1'b1;
					else screen_d = advance_screen(screen_d, cfg.screen_count);
				end else begin
					screen_d = advance_screen(screen_d, cfg.screen_count);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q      <= ScrHome;
			auto_q        <= 1'b1;
			last_auto_q   <= '0;
			last_click_q  <= '0;
			press_start_q <= '0;
			held_q        <= 1'b0;
		end else if (en) begin
			screen_q      <= screen_d;
			auto_q        <= auto_d;
			last_auto_q   <= last_auto_d;
			last_click_q  <= last_click_d;
			press_start_q <= press_start_d;
			held_q        <= held_d;
		end
	end

	assign res.screen          = screen_d;
	assign res.auto_mode       = auto_d;
	assign res.next_expression = expr_d;
	assign res.toggle_ip       = ip_d;

endmodule

[sv/bmss_checker.sv]
// Port-level checker for the screen selector and its bind.
module bmss_checker import bmss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// Both actions never fire on the same beat.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.next_expression && out_data.toggle_ip))
		else $error("both action pulses set");

	a_expr_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.next_expression |-> out_data.screen == ScrHome && !out_data.auto_mode)
		else $error("next_expression off home screen or in auto mode");

	a_ip_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.toggle_ip |-> out_data.screen == ScrIp && !out_data.auto_mode)
		else $error("toggle_ip off IP screen or in auto mode");

	// An empty output slot always leaves room for a new poll.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");

endmodule

bind button_menu_screen_selector bmss_checker u_bmss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/tb.sv]
// Self-checking testbench for the button menu screen selector.
module tb import bmss_pkg::*; ();

	localparam int unsigned StallLimit = 2000;
	localparam logic [CfgIdxW-1:0] RegNone = REG_SCREEN_COUNT + 3'd1;

	// Shadow of the selector: config, state and the views still owed by the block.
	class selector_track;
		logic [TimeW-1:0] period_ms, return_ms, long_ms, bounce_ms;
		logic [CntW-1:0]  n_screens;
		logic [ScrW-1:0]  cur_scr;
		logic             auto_on;
		logic [TimeW-1:0] t_switch, t_click, t_press;
		logic             held;
		out_t             views_due[$];
		int unsigned      views_seen;
		int unsigned      errors;

		function new();
			period_ms  = AutoPeriodRst;
			return_ms  = ReturnAutoRst;
			long_ms    = LongPressRst;
			bounce_ms  = DebounceRst;
			n_screens  = ScreenCountRst;
			cur_scr    = ScrHome;
			auto_on    = 1'b1;
			t_switch   = '0;
			t_click    = '0;
			t_press    = '0;
			held       = 1'b0;
			views_seen = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
			case (idx)
				REG_AUTO_PERIOD:  period_ms = val;
				REG_RETURN_AUTO:  return_ms = val;
				REG_LONG_PRESS:   long_ms = val;
				REG_DEBOUNCE:     bounce_ms = val;
				REG_SCREEN_COUNT: n_screens = val[CntW-1:0];
				default: ;
			endcase
		endfunction

		function void note_poll(in_t p);
			logic [TimeW-1:0] since;
			logic [TimeW-1:0] dur;
			int unsigned      n;
			logic [ScrW-1:0]  adv;
			logic             is_long;
			out_t             v;
			v = '0;
			if (auto_on) begin
				since = p.now_ms - t_switch;
				if (since > period_ms) begin
					cur_scr = (cur_scr == ScrHome) ? ScrAlt : ScrHome;
					t_switch = p.now_ms;
				end
			end else begin
				since = p.now_ms - t_click;
				if (since > return_ms) begin
					auto_on = 1'b1;
					cur_scr = ScrHome;
					t_switch = p.now_ms;
				end
			end
			if (!p.button_released && !held) begin
				held = 1'b1;
				t_press = p.now_ms;
			end else if (p.button_released && held) begin
				dur = p.now_ms - t_press;
				held = 1'b0;
				if (dur > bounce_ms) begin
					is_long = (dur >= long_ms);
					// clamp the count to 1..8 before wrapping
					n = (n_screens == 0) ? 1 : (n_screens > 8) ? 8 : n_screens;
					adv = ScrW'((int'(cur_scr) + 1) % n);
					t_click = p.now_ms;
					auto_on = 1'b0;
					if (cur_scr == ScrHome) begin
						if (is_long) cur_scr = adv;
						else v.next_expression = 1'b1;
					end else if (cur_scr == ScrIp) begin
						if (is_long) v.toggle_ip = 1'b1;
						else cur_scr = adv;
					end else begin
						cur_scr = adv;
					end
				end
			end
			v.screen = cur_scr;
			v.auto_mode = auto_on;
			views_due.push_back(v);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 100)
				$display("mismatch %s: got %0d expected %0d", what, got, want);
		endtask

		task check_result(out_t got);
			out_t want;
			if (views_due.size() == 0) begin
				report("result beat with nothing queued", 32'(got), 32'd0);
			end else begin
				want = views_due.pop_front();
				views_seen++;
				if (got.screen !== want.screen)
					report("screen", 32'(got.screen), 32'(want.screen));
				if (got.auto_mode !== want.auto_mode)
					report("auto_mode", 32'(got.auto_mode), 32'(want.auto_mode));
				if (got.next_expression !== want.next_expression)
					report("next_expression", 32'(got.next_expression),
						32'(want.next_expression));
				if (got.toggle_ip !== want.toggle_ip)
					report("toggle_ip", 32'(got.toggle_ip), 32'(want.toggle_ip));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_t                in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_t               out_data;
	logic               cfg_wen = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [TimeW-1:0]   cfg_wdata = '0;

	selector_track sb;
	bit            vld_q = 1'b0;
	bit            calm = 1'b0;
	logic [31:0]   t_ms = '0;
	int unsigned   polls_sent = 0;
	int unsigned   ready_left = 0;
	int unsigned   quiet = 0;

	button_menu_screen_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [31:0] step_ms();
		case ($urandom_range(0, 7))
			0: return sb.period_ms;
			1: return sb.period_ms + 32'd1;
			2: return sb.return_ms;
			3: return sb.return_ms + 32'd1;
			4: return $urandom;
			5: return $urandom_range(0, 20);
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	function automatic logic [31:0] hold_ms();
		case ($urandom_range(0, 7))
			0: return sb.bounce_ms;
			1: return sb.bounce_ms + 32'd1;
			2: return sb.long_ms - 32'd1;
			3: return sb.long_ms;
			4: return sb.long_ms + 32'd1;
			5: return $urandom_range(0, 3);
			6: return $urandom;
			default: return sb.bounce_ms + 32'd1 + $urandom_range(0, 600);
		endcase
	endfunction

	function automatic logic [31:0] pick_ms();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(1, 2000);
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 15);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	// Output side: random runs of ready high and low, steady high when calm.
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_left == 0) begin
			out_ready <= ($urandom_range(0, 99) < 65);
			ready_left <= gap_len() + 1;
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_poll(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet == StallLimit) begin
				$display("button_menu_screen_selector verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task send_poll(logic [31:0] stamp, logic rel);
		in_t         p;
		int unsigned gap;
		p.now_ms = stamp;
		p.button_released = rel;
		in_valid <= 1'b1;
		in_data <= p;
		vld_q = 1'b1;
		do @(posedge clk); while (!in_ready);
		polls_sent++;
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			vld_q = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every beat sent has come back.
	task drain();
		if (vld_q) begin
			in_valid <= 1'b0;
			vld_q = 1'b0;
		end
		while (sb.views_seen != polls_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task cfg_put(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task program_regs(logic [31:0] per, logic [31:0] ret, logic [31:0] lng,
			logic [31:0] deb, logic [31:0] cnt);
		drain();
		// an unused index must leave everything alone
		cfg_put(RegNone + CfgIdxW'($urandom_range(0, 2)), $urandom);
		cfg_put(REG_AUTO_PERIOD, per);
		cfg_put(REG_RETURN_AUTO, ret);
		cfg_put(REG_LONG_PRESS, lng);
		cfg_put(REG_DEBOUNCE, deb);
		cfg_put(REG_SCREEN_COUNT, cnt);
		cfg_wen <= 1'b0;
	endtask

	task run_polls(int unsigned n_polls);
		int unsigned target;
		int unsigned kind;
		logic [31:0] dur;
		logic [31:0] pt;
		target = polls_sent + n_polls;
		calm = ($urandom_range(0, 3) == 0);
		while (polls_sent < target) begin
			if (polls_sent == target - n_polls / 2) calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// well-formed click: idle polls, press, held polls, release
				repeat ($urandom_range(0, 2)) begin
					t_ms += step_ms();
					send_poll(t_ms, 1'b1);
				end
				t_ms += $urandom_range(0, 50);
				pt = t_ms;
				dur = hold_ms();
				send_poll(pt, 1'b0);
				repeat ($urandom_range(0, 2)) send_poll(pt + (dur >> $urandom_range(1, 3)), 1'b0);
				t_ms = pt + dur;
				send_poll(t_ms, 1'b1);
			end else if (kind < 88) begin
				t_ms += step_ms();
				send_poll(t_ms, 1'($urandom_range(0, 1)));
			end else begin
				pt = $urandom;
				if ($urandom_range(0, 1) == 1) t_ms = pt;
				send_poll(pt, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk at reset defaults
		send_poll(32'd0, 1'b1);
		send_poll(32'd5000, 1'b1);     // exactly the period: hold
		send_poll(32'd5001, 1'b1);     // toggle to screen 1
		send_poll(32'd5002, 1'b0);
		send_poll(32'd5003, 1'b0);     // press while held is ignored
		send_poll(32'd5052, 1'b1);     // exactly the debounce time: no click
		send_poll(32'd5053, 1'b1);     // release while not held is ignored
		send_poll(32'd5100, 1'b0); send_poll(32'd5151, 1'b1);
		send_poll(32'd5200, 1'b0); send_poll(32'd5800, 1'b1);
		send_poll(32'd5900, 1'b0); send_poll(32'd6900, 1'b1);
		send_poll(32'd7000, 1'b0); send_poll(32'd7499, 1'b1);
		send_poll(32'd7600, 1'b0); send_poll(32'd7700, 1'b1);
		send_poll(32'd7800, 1'b0); send_poll(32'd7900, 1'b1);
		send_poll(32'd8000, 1'b0); send_poll(32'd8500, 1'b1);
		send_poll(32'd23500, 1'b1);    // idle exactly the timeout: stay manual
		send_poll(32'd23501, 1'b1);    // back to auto on screen 0
		send_poll(32'hFFFF_FFFF, 1'b0);
		send_poll(32'h0000_0040, 1'b1); // press spans the timestamp wrap

		program_regs(32'd20, 32'd60, 32'd10, 32'd3, 32'd5);
		run_polls(200);
		program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		run_polls(200);
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'hFFFF_FFF9);
		run_polls(200);
		program_regs(32'd5000, 32'd15000, 32'd500, 32'd50, 32'd8);
		run_polls(200);
		program_regs(32'd30, 32'd90, 32'd40, 32'd5, 32'd15);
		run_polls(150);
		repeat (5) begin
			program_regs(pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_count());
			run_polls(150);
		end

		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("button_menu_screen_selector verification clean");
		else
			$display("button_menu_screen_selector verification failed");
		$finish;
	end

endmodule
